@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/rap_pkg.sv @@
// Shared types and constants of the random access response parser.
package rap_pkg;

    localparam int DEFAULT_NUM_PREAMBLE_IDS = 64;
    localparam int MASK_W                   = 64;
    localparam int SHIFT_W                  = 48;

    // Entry kind codes
    localparam logic [1:0] KIND_BACKOFF = 2'd0;
    localparam logic [1:0] KIND_RAPID   = 2'd1;
    localparam logic [1:0] KIND_RAR     = 2'd2;

    // Last RAR byte index; body bytes 1..6 are shifted in before it
    localparam logic [2:0] BODY_LAST = 3'd7;
    localparam logic [2:0] BODY_NONE = 3'd0;
    localparam logic [2:0] BODY_FIRST = 3'd1;

    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       pdu_start;
    } item_t;

    typedef struct packed {
        logic [1:0]  entry_kind;
        logic [5:0]  preamble_id;
        logic [3:0]  backoff_value;
        logic [11:0] ta_cmd;
        logic [26:0] uplink_grant;
        logic [15:0] temp_rnti;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/rap_in_stage.sv @@
// Input register stage of the random access response parser.
module rap_in_stage
    import rap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pdu_byte,
    input  logic       pdu_start,
    input  logic       take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Stall only while a held item cannot move on
    assign in_stall   = valid_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Fill on accept, drain on take
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pdu_byte  <= pdu_byte;
            item_reg.pdu_start <= pdu_start;
        end
    end

endmodule

@@ rtl/core/rap_parse.sv @@
// Parser state, SI mask and result register of the random access response parser.
module rap_parse
    import rap_pkg::*;
#(
    parameter int NUM_PREAMBLE_IDS = DEFAULT_NUM_PREAMBLE_IDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    input  logic              item_valid,
    input  item_t             item,
    output logic              take,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           result
);

    localparam int IDX_W = (NUM_PREAMBLE_IDS > 1) ? $clog2(NUM_PREAMBLE_IDS) : 1;

    logic [NUM_PREAMBLE_IDS-1:0] mask_reg;

    logic [2:0]         body_index_reg, body_index_next;
    logic               more_reg, more_next;
    logic [5:0]         held_id_reg, held_id_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               pdu_done_reg, pdu_done_next;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic [2:0]         idx_cur;
    logic               more_cur;
    logic [5:0]         held_cur;
    logic [SHIFT_W-1:0] shift_cur;
    logic               done_cur;
    logic               fire;
    logic               produce;
    logic               rapid_hit;
    logic [7:0]         b;

    // Output slot is free when empty or being taken
    assign take      = !out_valid_reg || !out_stall;
    assign fire      = item_valid && take;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign b         = item.pdu_byte;

    // SI-request lookup; ids past the mask never hit
    assign rapid_hit = ({1'b0, b[5:0]} < 7'(NUM_PREAMBLE_IDS))
                       && mask_reg[b[IDX_W-1:0]];

    // Parse one byte
    always_comb
    begin
        idx_cur   = body_index_reg;
        more_cur  = more_reg;
        held_cur  = held_id_reg;
        shift_cur = shift_reg;
        done_cur  = pdu_done_reg;
        if (item.pdu_start)
        begin
            idx_cur   = BODY_NONE;
            more_cur  = 1'b0;
            held_cur  = 6'd0;
            shift_cur = '0;
            done_cur  = 1'b0;
        end

        body_index_next = idx_cur;
        more_next       = more_cur;
        held_id_next    = held_cur;
        shift_next      = shift_cur;
        pdu_done_next   = done_cur;
        produce         = 1'b0;
        result_next     = '0;

        if (!done_cur)
        begin
            if (idx_cur == BODY_NONE)
            begin
                more_next = b[7];
                if (!b[6])
                begin
                    produce                   = 1'b1;
                    result_next.entry_kind    = KIND_BACKOFF;
                    result_next.backoff_value = b[3:0];
                    result_next.last          = !b[7];
                end
                else if (rapid_hit)
                begin
                    produce                 = 1'b1;
                    result_next.entry_kind  = KIND_RAPID;
                    result_next.preamble_id = b[5:0];
                    result_next.last        = !b[7];
                end
                else
                begin
                    held_id_next    = b[5:0];
                    shift_next      = '0;
                    body_index_next = BODY_FIRST;
                end
            end
            else if (idx_cur != BODY_LAST)
            begin
                shift_next      = {shift_cur[SHIFT_W-9:0], b};
                body_index_next = idx_cur + 3'd1;
            end
            else
            begin
                produce                  = 1'b1;
                result_next.entry_kind   = KIND_RAR;
                result_next.preamble_id  = held_cur;
                result_next.ta_cmd       = {shift_cur[46:40], shift_cur[39:35]};
                result_next.uplink_grant = {shift_cur[34:32], shift_cur[31:8]};
                result_next.temp_rnti    = {shift_cur[7:0], b};
                result_next.last         = !more_cur;
            end

            // Close the entry and clear the parser
            if (produce)
            begin
                if (!more_next)
                begin
                    pdu_done_next = 1'b1;
                end
                body_index_next = BODY_NONE;
                more_next       = 1'b0;
                held_id_next    = 6'd0;
                shift_next      = '0;
            end
        end

        // Refill or drain the result slot
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = fire && produce;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            body_index_reg <= BODY_NONE;
            more_reg       <= 1'b0;
            held_id_reg    <= 6'd0;
            shift_reg      <= '0;
            pdu_done_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data[NUM_PREAMBLE_IDS-1:0];
            end
            if (fire)
            begin
                body_index_reg <= body_index_next;
                more_reg       <= more_next;
                held_id_reg    <= held_id_next;
                shift_reg      <= shift_next;
                pdu_done_reg   <= pdu_done_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/core/random_access_response_parser.sv @@
// Top level of the random access response parser.
//
// Takes one PDU byte per cycle while in_stall is low and gives one item per
// subheader without a body or per completed 7-byte MAC RAR. An accepted byte
// sits in an input register and is parsed from there when the result slot
// is free; its item, if any, is then loaded into the result register. Bytes
// keep flowing at one per cycle while results are taken; a stalled result
// holds the input register, and with it in_stall, until the result slot
// drains. The user must write the SI mask with cfg_wr_en/cfg_wr_data only
// while the parser is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module random_access_response_parser
    import rap_pkg::*;
#(
    parameter int NUM_PREAMBLE_IDS = DEFAULT_NUM_PREAMBLE_IDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        pdu_byte,
    input  logic              pdu_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        entry_kind,
    output logic [5:0]        preamble_id,
    output logic [3:0]        backoff_value,
    output logic [11:0]       ta_cmd,
    output logic [26:0]       uplink_grant,
    output logic [15:0]       temp_rnti,
    output logic              last
);

    logic    item_valid;
    item_t   item;
    logic    take;
    result_t result;

    // Input register
    rap_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pdu_byte   (pdu_byte),
        .pdu_start  (pdu_start),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser and result register
    rap_parse #(
        .NUM_PREAMBLE_IDS (NUM_PREAMBLE_IDS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result)
    );

    // Unpack the result
    assign entry_kind     = result.entry_kind;
    assign preamble_id    = result.preamble_id;
    assign backoff_value  = result.backoff_value;
    assign ta_cmd         = result.ta_cmd;
    assign uplink_grant   = result.uplink_grant;
    assign temp_rnti      = result.temp_rnti;
    assign last           = result.last;

    // RAR-only fields stay zero on subheader-only entries
    `RAP_ASSERT_IMP(a_hdr_zero, clk, rst_n, out_valid && (entry_kind != KIND_RAR), (ta_cmd == 12'd0) && (uplink_grant == 27'd0) && (temp_rnti == 16'd0))
    // Backoff entries carry no preamble id, id entries no backoff
    `RAP_ASSERT_IMP(a_bi_only, clk, rst_n, out_valid && (entry_kind == KIND_BACKOFF), preamble_id == 6'd0)
    `RAP_ASSERT_IMP(a_id_only, clk, rst_n, out_valid && (entry_kind != KIND_BACKOFF), backoff_value == 4'd0)
    // A stalled result keeps the input register stalled once it is full
    `RAP_ASSERT_NXT(a_hold_in, clk, rst_n, out_valid && out_stall && in_valid && !in_stall, in_stall || !out_stall)

endmodule
